FILE: rtl/t3270_pkg.sv
// shared types, codes and conversion functions for the 3270 receive decoder
`timescale 1ns / 1ps
package t3270_pkg;

  typedef enum logic [1:0] {
    MODE_ASCII_ANSI  = 2'd0,
    MODE_EBCDIC_ANSI = 2'd1,
    MODE_3270        = 2'd2,
    MODE_3270_HEX    = 2'd3
  } term_mode_t;

  typedef enum logic [1:0] {
    CFG_TERM_MODE   = 2'd0,
    CFG_HEADER_SKIP = 2'd1,
    CFG_DATA_LIMIT  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef enum logic {
    EV_CHAR     = 1'b0,
    EV_KBD_TURN = 1'b1
  } event_kind_t;

  localparam int unsigned CountW = 11;

  localparam logic [7:0]        XON_CODE    = 8'h11;
  localparam logic [7:0]        IAC_CODE    = 8'hFF;
  localparam logic [7:0]        EOR_CODE    = 8'hEF;
  localparam logic [7:0]        KBD_UNLOCK  = 8'hC3;
  localparam logic [7:0]        CHAR_X      = 8'h58;
  localparam logic [CountW-1:0] COUNT_MAX   = 11'd2047;
  localparam logic [CountW-1:0] KBD_POS     = 11'd2;
  localparam logic [CountW-1:0] HEADER_RST  = 11'd7;
  localparam logic [CountW-1:0] LIMIT_RST   = 11'd1767;
  localparam term_mode_t        MODE_RST    = MODE_ASCII_ANSI;

  // per-record decoder state
  typedef struct packed {
    logic              iac_pending;
    logic [CountW-1:0] record_count;
    logic [7:0]        keyboard_code;
    logic              ignore_rest;
    logic              hex_pending;
    logic [3:0]        hex_high;
  } dec_state_t;

  typedef struct packed {
    term_mode_t        term_mode;
    logic [CountW-1:0] header_skip;
    logic [CountW-1:0] data_limit;
  } dec_cfg_t;

  // ebcdic to local character, zero when unmapped
  function automatic logic [7:0] ebc_to_local(input logic [7:0] b);
    logic [7:0] c;
    begin
      c = 8'h00;
      case (b) inside
        [8'h81:8'h89]: c = b - 8'h20;
        [8'h91:8'h99]: c = b - 8'h27;
        [8'hA2:8'hA9]: c = b - 8'h2F;
        [8'hC1:8'hC9]: c = b - 8'h80;
        [8'hD1:8'hD9]: c = b - 8'h87;
        [8'hE2:8'hE9]: c = b - 8'h8F;
        [8'hF0:8'hF9]: c = b - 8'hC0;
        8'h15, 8'h25:  c = 8'h0A;
        8'h27:         c = 8'h1B;
        8'h40:         c = 8'h20;
        8'h5A:         c = 8'h21;
        8'h7F:         c = 8'h22;
        8'h7B:         c = 8'h23;
        8'h5B:         c = 8'h24;
        8'h6C:         c = 8'h25;
        8'h50:         c = 8'h26;
        8'h7D:         c = 8'h27;
        8'h4D:         c = 8'h28;
        8'h5D:         c = 8'h29;
        8'h5C:         c = 8'h2A;
        8'h4E:         c = 8'h2B;
        8'h6B:         c = 8'h2C;
        8'h60:         c = 8'h2D;
        8'h4B:         c = 8'h2E;
        8'h61:         c = 8'h2F;
        8'h7A:         c = 8'h3A;
        8'h5E:         c = 8'h3B;
        8'h4C:         c = 8'h3C;
        8'h7E:         c = 8'h3D;
        8'h6E:         c = 8'h3E;
        8'h6F:         c = 8'h3F;
        8'h7C:         c = 8'h40;
        8'hAD:         c = 8'h5B;
        8'hE0:         c = 8'h5C;
        8'hBD:         c = 8'h5D;
        8'h5F:         c = 8'h5E;
        8'h6D:         c = 8'h5F;
        8'h79:         c = 8'h60;
        8'hC0:         c = 8'h7B;
        8'h4F:         c = 8'h7C;
        8'hD0:         c = 8'h7D;
        8'hA1:         c = 8'h7E;
        default:       c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // upper-case hex digit value in [3:0], bit 4 set when not a digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] d;
    begin
      d = 5'h10;
      if (c inside {[8'h30:8'h39]}) begin
        d = {1'b0, c[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        d = {1'b0, c[3:0] + 4'd9};
      end
      return d;
    end
  endfunction

endpackage

FILE: rtl/t3270_if.sv
// valid/ready channel interfaces for the receive byte, result and register write
`timescale 1ns / 1ps
interface t3270_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface t3270_res_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] char_out;
  modport source (output valid, output event_kind, output char_out, input ready);
  modport sink (input valid, input event_kind, input char_out, output ready);
endinterface

interface t3270_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/t3270_step.sv
// next-state and result logic for one received byte
`timescale 1ns / 1ps
module t3270_step (
  input  t3270_pkg::dec_cfg_t   cfg,
  input  t3270_pkg::dec_state_t st,
  input  logic [7:0]            rx_byte,
  output t3270_pkg::dec_state_t st_nxt,
  output logic                  res_valid,
  output logic                  res_kind,
  output logic [7:0]            res_char
);

  logic [7:0]                     conv_b;
  logic [4:0]                     digit_b;
  logic [7:0]                     conv_pair;
  logic [t3270_pkg::CountW-1:0]   count_inc;
  logic [t3270_pkg::CountW-1:0]   count_now;
  logic                           is_data;
  logic [4:0]                     digit_c;

  assign conv_b    = t3270_pkg::ebc_to_local(rx_byte);
  assign digit_b   = t3270_pkg::hex_value(conv_b);
  assign conv_pair = t3270_pkg::ebc_to_local({st.hex_high, digit_b[3:0]});
  assign digit_c   = digit_b;
  assign count_inc = (st.record_count < t3270_pkg::COUNT_MAX) ?
                     st.record_count + 1'b1 : st.record_count;

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res_kind  = t3270_pkg::EV_CHAR;
    res_char  = 8'h00;
    is_data   = 1'b0;
    count_now = st.record_count;
    case (cfg.term_mode)
      t3270_pkg::MODE_ASCII_ANSI: begin
        res_valid = 1'b1;
        if (rx_byte == t3270_pkg::XON_CODE) begin
          res_kind = t3270_pkg::EV_KBD_TURN;
        end else begin
          res_char = rx_byte;
        end
      end
      t3270_pkg::MODE_EBCDIC_ANSI: begin
        if (rx_byte == t3270_pkg::XON_CODE) begin
          res_valid = 1'b1;
          res_kind  = t3270_pkg::EV_KBD_TURN;
        end else if (conv_b != 8'h00) begin
          res_valid = 1'b1;
          res_char  = conv_b;
        end
      end
      default: begin
        if (cfg.term_mode == t3270_pkg::MODE_3270_HEX && st.hex_pending) begin
          // low digit: taken raw, no iac, header or limit test
          st_nxt.hex_pending  = 1'b0;
          st_nxt.record_count = count_inc;
          if (digit_b[4] || conv_pair == 8'h00) begin
            st_nxt.ignore_rest = 1'b1;
          end else begin
            res_valid = 1'b1;
            res_char  = conv_pair;
          end
        end else begin
          if (st.iac_pending) begin
            st_nxt.iac_pending = 1'b0;
            if (rx_byte == t3270_pkg::EOR_CODE) begin
              st_nxt.record_count = '0;
              st_nxt.ignore_rest  = 1'b0;
              if (st.keyboard_code == t3270_pkg::KBD_UNLOCK) begin
                res_valid = 1'b1;
                res_kind  = t3270_pkg::EV_KBD_TURN;
              end
            end else if (rx_byte == t3270_pkg::IAC_CODE) begin
              is_data = 1'b1;
            end
          end else begin
            st_nxt.record_count = count_inc;
            count_now           = count_inc;
            if (rx_byte == t3270_pkg::IAC_CODE) begin
              st_nxt.iac_pending = 1'b1;
            end else begin
              is_data = 1'b1;
            end
          end
          if (is_data) begin
            if (count_now == t3270_pkg::KBD_POS) begin
              st_nxt.keyboard_code = rx_byte;
            end
            if (count_now > cfg.header_skip && count_now <= cfg.data_limit) begin
              if (cfg.term_mode == t3270_pkg::MODE_3270) begin
                if (conv_b != 8'h00) begin
                  res_valid = 1'b1;
                  res_char  = conv_b;
                end
              end else if (conv_b == t3270_pkg::CHAR_X) begin
                st_nxt.ignore_rest = 1'b1;
              end else if (!st.ignore_rest) begin
                if (digit_c[4]) begin
                  st_nxt.ignore_rest = 1'b1;
                end else begin
                  st_nxt.hex_high    = digit_c[3:0];
                  st_nxt.hex_pending = 1'b1;
                end
              end
            end
          end
        end
      end
    endcase
  end

endmodule

FILE: rtl/telnet_3270_rx_stream_decoder.sv
// top level of the 3270 receive stream decoder
`timescale 1ns / 1ps
//
// channel  | dir | payload                         | handshake
// ---------+-----+---------------------------------+-------------
// in_rx    | in  | rx_byte[7:0]                    | valid/ready
// out_res  | out | event_kind, char_out[7:0]       | valid/ready
// cfg_wr   | in  | index[1:0], data[10:0]          | valid/ready
//
// one byte per cycle sustained while out_res.ready stays high; a byte passes
// from its beat through the input register and then the result register
// the step logic and the decoder state advance together in a single cycle
// rst_n is synchronous; it clears both valid flags, the decoder state and
// loads the register reset values
// a stalled result holds; the input register still takes one more beat
// behind it, then in_rx.ready drops until the result is taken
// cfg_wr is always ready; writes to index 3 are dropped
//
module telnet_3270_rx_stream_decoder (
  input logic              clk,
  input logic              rst_n,
  t3270_rx_if.sink         in_rx,
  t3270_res_if.source      out_res,
  t3270_cfg_if.sink        cfg_wr
);

  // configuration registers
  t3270_pkg::dec_cfg_t   cfg_r;

  // input register
  logic                  in_vld_r;
  logic [7:0]            in_byte_r;

  // decoder state
  t3270_pkg::dec_state_t st_r;
  t3270_pkg::dec_state_t st_nxt;

  // result register
  logic                  out_vld_r;
  logic                  out_kind_r;
  logic [7:0]            out_char_r;

  logic                  res_valid;
  logic                  res_kind;
  logic [7:0]            res_char;
  logic                  proc_fire;
  logic                  in_beat;

  // process the held byte once the result register has room
  assign proc_fire = in_vld_r && (!out_vld_r || out_res.ready);
  assign in_beat   = in_rx.valid && in_rx.ready;

  assign in_rx.ready        = !in_vld_r || proc_fire;
  assign cfg_wr.ready       = 1'b1;
  assign out_res.valid      = out_vld_r;
  assign out_res.event_kind = out_kind_r;
  assign out_res.char_out   = out_char_r;

  t3270_step u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .rx_byte   (in_byte_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res_kind  (res_kind),
    .res_char  (res_char)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.term_mode   <= t3270_pkg::MODE_RST;
      cfg_r.header_skip <= t3270_pkg::HEADER_RST;
      cfg_r.data_limit  <= t3270_pkg::LIMIT_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        t3270_pkg::CFG_TERM_MODE:   cfg_r.term_mode   <= t3270_pkg::term_mode_t'(cfg_wr.data[1:0]);
        t3270_pkg::CFG_HEADER_SKIP: cfg_r.header_skip <= cfg_wr.data;
        t3270_pkg::CFG_DATA_LIMIT:  cfg_r.data_limit  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rx.ready) begin
      in_vld_r <= in_rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_byte_r <= in_rx.rx_byte;
    end
  end

  // decoder state moves only when a byte is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (proc_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_fire) begin
      out_vld_r <= res_valid;
    end else if (out_res.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_valid) begin
      out_kind_r <= res_kind;
      out_char_r <= res_char;
    end
  end

endmodule

FILE: rtl/t3270_checker.sv
// port-level checks for the 3270 receive decoder, bound to the top level
`timescale 1ns / 1ps
module t3270_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_char
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // keyboard turn carries a zero character
  a_kbd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_char == 8'h00)
    else $error("keyboard turn with nonzero character");

  // input stalls only behind a stalled result
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // a fresh result follows an input beat through the input and result registers
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an input beat");

endmodule

bind telnet_3270_rx_stream_decoder t3270_checker u_t3270_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_rx.valid),
  .in_ready  (in_rx.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_kind  (out_res.event_kind),
  .out_char  (out_res.char_out)
);

FILE: test/tb_telnet_3270_rx_stream_decoder.sv
// self-checking testbench for the 3270 receive stream decoder
`timescale 1ns / 1ps
module tb_telnet_3270_rx_stream_decoder;

  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         DRAIN_CYCLES = 8;     // two-stage pipe plus margin
  localparam int         PHASE_BEATS  = 34;
  localparam int         NUM_PHASES   = 16;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [7:0] EBC_DIGIT_0  = 8'hF0;
  localparam logic [7:0] EBC_LETTER_A = 8'hC1;
  localparam logic [7:0] EBC_LETTER_X = 8'hE7;

  // predicts decoder output per accepted byte and checks what comes out
  class decoder_scoreboard;
    typedef struct {
      t3270_pkg::event_kind_t kind;
      logic [7:0]             ch;
    } disp_evt_t;

    t3270_pkg::term_mode_t        mode;
    logic [t3270_pkg::CountW-1:0] hdr_skip;
    logic [t3270_pkg::CountW-1:0] trail_limit;
    bit                           iac_seen;
    bit [t3270_pkg::CountW-1:0]   rec_cnt;
    bit [7:0]                     kbd_code;
    bit                           skip_text;
    bit                           low_digit_due;
    bit [3:0]                     high_nibble;
    bit [7:0]                     ebc_map[256];
    disp_evt_t                    expected_q[$];
    int                           errors;

    function new();
      bit [7:0] punct_codes[33] = '{
        8'h40, 8'h5A, 8'h7F, 8'h7B, 8'h5B, 8'h6C, 8'h50, 8'h7D, 8'h4D, 8'h5D, 8'h5C,
        8'h4E, 8'h6B, 8'h60, 8'h4B, 8'h61, 8'h7A, 8'h5E, 8'h4C, 8'h7E, 8'h6E, 8'h6F,
        8'h7C, 8'hAD, 8'hE0, 8'hBD, 8'h5F, 8'h6D, 8'h79, 8'hC0, 8'h4F, 8'hD0, 8'hA1};
      string punct_chars = " !\"#$%&'()*+,-./:;<=>?@[\\]^_`{|}~";
      foreach (ebc_map[i]) ebc_map[i] = 8'h00;
      for (int i = 0; i < 10; i++) ebc_map[8'hF0 + i] = "0" + i;
      for (int i = 0; i < 9; i++) begin
        ebc_map[8'h81 + i] = "a" + i;
        ebc_map[8'h91 + i] = "j" + i;
        ebc_map[8'hC1 + i] = "A" + i;
        ebc_map[8'hD1 + i] = "J" + i;
      end
      for (int i = 0; i < 8; i++) begin
        ebc_map[8'hA2 + i] = "s" + i;
        ebc_map[8'hE2 + i] = "S" + i;
      end
      for (int i = 0; i < 33; i++) ebc_map[punct_codes[i]] = punct_chars[i];
      ebc_map[8'h15] = 8'h0A;
      ebc_map[8'h25] = 8'h0A;
      ebc_map[8'h27] = 8'h1B;
      mode        = t3270_pkg::MODE_RST;
      hdr_skip    = t3270_pkg::HEADER_RST;
      trail_limit = t3270_pkg::LIMIT_RST;
      errors      = 0;
    endfunction

    function void write_reg(t3270_pkg::cfg_index_t idx, logic [t3270_pkg::CountW-1:0] val);
      case (idx)
        t3270_pkg::CFG_TERM_MODE:   mode = t3270_pkg::term_mode_t'(val[1:0]);
        t3270_pkg::CFG_HEADER_SKIP: hdr_skip = val;
        t3270_pkg::CFG_DATA_LIMIT:  trail_limit = val;
        default: ;
      endcase
    endfunction

    // upper-case hex digit value, bit 4 set when not a digit
    function bit [4:0] hex_digit(bit [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
      return 5'h10;
    endfunction

    function void bump_count();
      if (rec_cnt != t3270_pkg::COUNT_MAX) rec_cnt++;
    endfunction

    function bit predict(bit [7:0] b, output t3270_pkg::event_kind_t kind,
                         output logic [7:0] ch);
      bit [7:0] c;
      bit [4:0] d;
      kind = t3270_pkg::EV_CHAR;
      ch   = 8'h00;
      if (mode == t3270_pkg::MODE_ASCII_ANSI || mode == t3270_pkg::MODE_EBCDIC_ANSI) begin
        if (b == t3270_pkg::XON_CODE) begin
          kind = t3270_pkg::EV_KBD_TURN;
          return 1'b1;
        end
        ch = (mode == t3270_pkg::MODE_ASCII_ANSI) ? b : ebc_map[b];
        return ch != 8'h00 || mode == t3270_pkg::MODE_ASCII_ANSI;
      end
      // second hex digit goes raw, no telnet or window handling
      if (mode == t3270_pkg::MODE_3270_HEX && low_digit_due) begin
        low_digit_due = 1'b0;
        bump_count();
        d = hex_digit(ebc_map[b]);
        if (d[4]) begin
          skip_text = 1'b1;
          return 1'b0;
        end
        ch = ebc_map[{high_nibble, d[3:0]}];
        if (ch == 8'h00) begin
          skip_text = 1'b1;
          return 1'b0;
        end
        return 1'b1;
      end
      if (iac_seen) begin
        iac_seen = 1'b0;
        if (b == t3270_pkg::EOR_CODE) begin
          rec_cnt   = '0;
          skip_text = 1'b0;
          if (kbd_code == t3270_pkg::KBD_UNLOCK) begin
            kind = t3270_pkg::EV_KBD_TURN;
            return 1'b1;
          end
          return 1'b0;
        end
        if (b != t3270_pkg::IAC_CODE) return 1'b0;
      end else begin
        bump_count();
        if (b == t3270_pkg::IAC_CODE) begin
          iac_seen = 1'b1;
          return 1'b0;
        end
      end
      if (rec_cnt == t3270_pkg::KBD_POS) kbd_code = b;
      if (rec_cnt <= hdr_skip || rec_cnt > trail_limit) return 1'b0;
      c = ebc_map[b];
      if (mode == t3270_pkg::MODE_3270) begin
        ch = c;
        return c != 8'h00;
      end
      if (c == t3270_pkg::CHAR_X) begin
        skip_text = 1'b1;
        return 1'b0;
      end
      if (skip_text) return 1'b0;
      d = hex_digit(c);
      if (d[4]) begin
        skip_text = 1'b1;
        return 1'b0;
      end
      high_nibble   = d[3:0];
      low_digit_due = 1'b1;
      return 1'b0;
    endfunction

    function void note_rx(logic [7:0] b);
      t3270_pkg::event_kind_t k;
      logic [7:0]             c;
      disp_evt_t              e;
      if (predict(b, k, c)) begin
        e.kind = k;
        e.ch   = c;
        expected_q.push_back(e);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(t3270_pkg::event_kind_t kind, logic [7:0] ch);
      disp_evt_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d char %02h", kind, ch));
      end else begin
        want = expected_q.pop_front();
        if (kind !== want.kind)
          report($sformatf("event_kind %0d, expected %0d", kind, want.kind));
        if (ch !== want.ch)
          report($sformatf("char_out %02h, expected %02h", ch, want.ch));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  t3270_rx_if  rx_ch();
  t3270_res_if res_ch();
  t3270_cfg_if cfg_ch();

  telnet_3270_rx_stream_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rx  (rx_ch),
    .out_res(res_ch),
    .cfg_wr (cfg_ch)
  );

  decoder_scoreboard sb;

  int sender_idle_pct = 0;   // chance per cycle that the byte source holds back
  int recv_stall_pct  = 0;   // chance per cycle that the result sink stalls
  int hold_left       = 0;   // long sink hold-off, counted down by the sink process
  int beats_sent      = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // every accepted byte beat goes to the predictor
  always @(posedge clk) begin
    if (rst_n && rx_ch.valid && rx_ch.ready) sb.note_rx(rx_ch.rx_byte);
  end

  // register writes update the predictor's copy of the configuration
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      sb.write_reg(t3270_pkg::cfg_index_t'(cfg_ch.index), cfg_ch.data);
  end

  // result sink: check each beat, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      sb.check_result(t3270_pkg::event_kind_t'(res_ch.event_kind), res_ch.char_out);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_telnet_3270_rx_stream_decoder NOT OK");
      $finish;
    end
  end

  // offer one byte, holding back at random first; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    beats_sent++;
  endtask

  // data byte, with a 0xff escaped as a doubled iac
  task automatic send_data(input logic [7:0] b);
    if (b == t3270_pkg::IAC_CODE) send_byte(t3270_pkg::IAC_CODE);
    send_byte(b);
  endtask

  task automatic send_eor();
    send_byte(t3270_pkg::IAC_CODE);
    send_byte(t3270_pkg::EOR_CODE);
  endtask

  function automatic logic [7:0] any_mapped();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (sb.ebc_map[b] == 8'h00);
    return b;
  endfunction

  // telnet command other than end of record or escaped iac
  function automatic logic [7:0] telnet_cmd();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == t3270_pkg::EOR_CODE || b == t3270_pkg::IAC_CODE);
    return b;
  endfunction

  function automatic logic [7:0] ebc_digit(input logic [3:0] v);
    return (v < 4'd10) ? EBC_DIGIT_0 + v : EBC_LETTER_A + (v - 4'd10);
  endfunction

  task automatic send_hex_pair(input logic [7:0] code);
    send_byte(ebc_digit(code[7:4]));
    send_byte(ebc_digit(code[3:0]));
  endtask

  // one 3270 record: header, body of text or hex pairs, mostly closed by eor
  task automatic send_record(input bit hex_body);
    int         hdr_len;
    int         pick;
    logic [7:0] b;
    hdr_len = (sb.hdr_skip > 10) ? 3 : int'(sb.hdr_skip);
    if ($urandom_range(9) == 0) hdr_len++;   // misaligned header now and then
    for (int i = 1; i <= hdr_len; i++) begin
      b = 8'($urandom_range(255));
      if (i == 2 && $urandom_range(1)) b = t3270_pkg::KBD_UNLOCK;
      send_data(b);
    end
    repeat ($urandom_range(14)) begin
      pick = $urandom_range(99);
      if (!hex_body) begin
        if (pick < 85) send_byte(any_mapped());
        else if (pick < 90) send_data(t3270_pkg::IAC_CODE);
        else if (pick < 95) begin
          send_byte(t3270_pkg::IAC_CODE);
          send_byte(telnet_cmd());
        end else send_byte(8'($urandom_range(255)));
      end else begin
        if (pick < 80) send_hex_pair(any_mapped());
        else if (pick < 85) send_hex_pair(8'($urandom_range(255)));
        else if (pick < 89) send_byte(EBC_LETTER_X);
        else if (pick < 93) send_byte(any_mapped());
        else if (pick < 97) begin
          send_byte(t3270_pkg::IAC_CODE);
          send_byte(telnet_cmd());
        end else send_byte(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(9) != 0) send_eor();
  endtask

  // drop valid and wait for every predicted result; always crosses an edge
  task automatic wait_results();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // idle the block fully: results drained plus bytes that give none
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write beat; valid is left high for back-to-back writes
  task automatic put_reg(input t3270_pkg::cfg_index_t idx,
                         input logic [t3270_pkg::CountW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // mode write with junk in the unused upper data bits
  task automatic write_mode(input t3270_pkg::term_mode_t m);
    put_reg(t3270_pkg::CFG_TERM_MODE, {9'($urandom_range(511)), m});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_regs(input t3270_pkg::term_mode_t m,
                            input logic [t3270_pkg::CountW-1:0] skip,
                            input logic [t3270_pkg::CountW-1:0] lim, input bit extra);
    put_reg(t3270_pkg::CFG_TERM_MODE, {9'($urandom_range(511)), m});
    put_reg(t3270_pkg::CFG_HEADER_SKIP, skip);
    put_reg(t3270_pkg::CFG_DATA_LIMIT, lim);
    // index 3 must be dropped
    if (extra) put_reg(t3270_pkg::CFG_UNUSED, 11'($urandom_range(2047)));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int                           start;
    t3270_pkg::term_mode_t        phase_mode;
    logic [t3270_pkg::CountW-1:0] skip_v;
    logic [t3270_pkg::CountW-1:0] lim_v;
    sb = new();
    rst_n          <= 1'b0;
    rx_ch.valid    <= 1'b0;
    rx_ch.rx_byte  <= 8'h00;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= t3270_pkg::CFG_TERM_MODE;
    cfg_ch.data    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mode is ascii: bytes pass, xon gives the keyboard turn
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(t3270_pkg::XON_CODE);
    send_byte(8'h55);
    send_byte(8'hAA);

    // ebcdic ansi: xon, letter, esc, newline, unmapped byte dropped
    settle();
    write_mode(t3270_pkg::MODE_EBCDIC_ANSI);
    send_byte(t3270_pkg::XON_CODE);
    send_byte(8'hC1);
    send_byte(8'h27);
    send_byte(8'h25);
    send_byte(8'h00);

    // plain 3270 with a tight window: header drop, keyboard code at count 2,
    // escaped iac as data, trailer drop, stray command, then a dangling iac
    settle();
    write_regs(t3270_pkg::MODE_3270, 11'd1, 11'd4, 1'b1);
    send_byte(8'h40);
    send_byte(t3270_pkg::KBD_UNLOCK);
    send_data(t3270_pkg::IAC_CODE);
    send_byte(8'hF1);
    send_byte(8'hF2);
    send_byte(t3270_pkg::IAC_CODE);
    send_byte(8'hF1);
    send_byte(t3270_pkg::IAC_CODE);

    // the pending iac survives a trip through ascii mode
    settle();
    write_mode(t3270_pkg::MODE_ASCII_ANSI);
    send_byte(t3270_pkg::EOR_CODE);
    settle();
    write_mode(t3270_pkg::MODE_3270);
    send_byte(t3270_pkg::EOR_CODE);

    // hex-embedded text: one pair, then 'X' ignores the rest of the record
    settle();
    write_regs(t3270_pkg::MODE_3270_HEX, '0, t3270_pkg::COUNT_MAX, 1'b0);
    send_hex_pair(EBC_LETTER_A);
    send_byte(EBC_LETTER_X);
    send_eor();

    // random phases over every mode and idle pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      phase_mode = t3270_pkg::term_mode_t'((ph + ph / 4) % 4);
      case (ph % 6)
        0: begin
          skip_v = '0;
          lim_v  = t3270_pkg::COUNT_MAX;
        end
        1: begin
          skip_v = t3270_pkg::COUNT_MAX;
          lim_v  = t3270_pkg::COUNT_MAX;
        end
        2: begin
          skip_v = 11'($urandom_range(8));
          lim_v  = '0;
        end
        default: begin
          skip_v = 11'($urandom_range(8));
          lim_v  = skip_v + 11'($urandom_range(25));
        end
      endcase
      settle();
      write_regs(phase_mode, skip_v, lim_v, 1'($urandom_range(1)));
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 70;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 70;
        end
        default: begin
          sender_idle_pct = 9;
          recv_stall_pct  = 9;
        end
      endcase
      // resync to a record boundary whatever iac state was left behind
      if (phase_mode == t3270_pkg::MODE_3270 || phase_mode == t3270_pkg::MODE_3270_HEX) begin
        send_eor();
        send_eor();
      end
      // long sink hold-off while the source keeps offering: pipe fills, input stalls
      if (ph == 4) hold_left = HOLD_CYCLES;
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        // source pauses mid-phase until the sink has caught up
        if (ph == 9 && beats_sent - start >= PHASE_BEATS / 2 && sb.pending() != 0)
          wait_results();
        if (phase_mode == t3270_pkg::MODE_3270 || phase_mode == t3270_pkg::MODE_3270_HEX)
          send_record(phase_mode == t3270_pkg::MODE_3270_HEX);
        else
          send_byte(($urandom_range(9) == 0) ? t3270_pkg::XON_CODE :
                    8'($urandom_range(255)));
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("tb_telnet_3270_rx_stream_decoder OK");
    end else begin
      $display("tb_telnet_3270_rx_stream_decoder NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/t3270_pkg.sv
rtl/t3270_if.sv
rtl/t3270_step.sv
rtl/telnet_3270_rx_stream_decoder.sv
rtl/t3270_checker.sv
test/tb_telnet_3270_rx_stream_decoder.sv
